// ----- src/oabs_pkg.sv -----
`default_nettype none

package oabs_pkg;

    // Store geometry.
    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int DATA_W = 32;

    // Field widths fixed by the transaction format.
    localparam int SLOT_W = 10;
    localparam int POS_W  = 10;
    localparam int CFG_W  = 10;
    localparam int CFG_ADDR_W = 1;

    // Signed search bounds need room for one below zero and one above DEPTH-1.
    localparam int PTR_W = IDX_W + 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RANGE_FIRST = 1'b0,
        REG_RANGE_LAST  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_DIR,
        ST_PROBE
    } state_t;

    typedef struct packed {
        logic                     op;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] datum;
    } cmd_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } result_t;

    // Bound registers at or above DEPTH saturate to the last entry.
    function automatic logic [IDX_W-1:0] clamp_idx(input logic [CFG_W-1:0] v);
        logic [IDX_W-1:0] r;
        if (32'(v) >= DEPTH) begin
            r = IDX_W'(DEPTH - 1);
        end
        else begin
            r = IDX_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/order_agnostic_binary_search.sv -----
`default_nettype none

// Channel   Ports                         Handshake
// -------   ---------------------------   -------------------------------------------
// command   start, busy, cmd              taken at an edge with start high, busy low
// result    done, result                  shown for one cycle while done is high
// config    cfg_we, cfg_addr, cfg_data    register written at an edge with cfg_we high
//
// A write transaction stores its word at the accept edge and its acknowledge appears in
// the following cycle. A search transaction first fetches the range's first and last
// elements and chooses the direction (ST_RD_FIRST, ST_RD_LAST, ST_DIR), then probes
// (at most log2(DEPTH)+1 probes, eleven for 1024 entries) until it hits or runs out of
// range, and its result is registered. A search whose bounds are reversed reads
// nothing and is answered in the following cycle, like a write. The single read port
// of the element memory sets the pace of the probes: each probe is one registered read
// followed by one compare.
// Reset clears the control state and sets the bounds to the whole store; the element memory
// is not cleared and holds undefined data until written. The result receiver cannot stall:
// busy drops in the cycle the result is shown, so a new transaction may be taken then.
module order_agnostic_binary_search
    import oabs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output      logic                  busy,
    input  wire cmd_t                  cmd,
    output      logic                  done,
    output      result_t               result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    // Element store, one synchronous read port and one write port.
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] range_first_reg;
    logic [CFG_W-1:0] range_last_reg;

    logic signed [PTR_W-1:0] lo_reg, hi_reg, mid_reg;
    logic signed [PTR_W-1:0] lo_next, hi_next, mid_next, mid_init;
    logic [DATA_W-1:0]       key_reg;
    logic [DATA_W-1:0]       first_val_reg;
    logic                    desc_reg;

    logic    done_reg, done_next;
    result_t result_reg, result_next;

    logic             accept;
    logic [IDX_W-1:0] first_idx, last_idx;
    logic             range_empty;
    logic             key_eq, key_gt, go_up, probe_empty, desc_now;

    assign accept    = start && !busy;
    assign first_idx = clamp_idx(range_first_reg);
    assign last_idx  = clamp_idx(range_last_reg);
    assign range_empty = first_idx > last_idx;
    assign mem_we    = accept && (cmd.op == OP_WRITE) && (32'(cmd.slot) < DEPTH);

    // Probe arithmetic. In ST_PROBE the read data is the element at mid_reg.
    always_comb
    begin
        key_eq   = key_reg == rdata_reg;
        key_gt   = $signed(key_reg) > $signed(rdata_reg);
        desc_now = $signed(first_val_reg) > $signed(rdata_reg);
        go_up    = key_gt != desc_reg;
        if (go_up)
        begin
            lo_next = mid_reg + PTR_W'(1);
            hi_next = hi_reg;
        end
        else
        begin
            lo_next = lo_reg;
            hi_next = mid_reg - PTR_W'(1);
        end
        probe_empty = lo_next > hi_next;
        mid_next    = lo_next + ((hi_next - lo_next) >>> 1);
        mid_init    = lo_reg + ((hi_reg - lo_reg) >>> 1);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.op == OP_SEARCH) && !range_empty)
                begin
                    state_next = ST_RD_FIRST;
                end
            end
            ST_RD_FIRST: state_next = ST_RD_LAST;
            ST_RD_LAST:  state_next = ST_DIR;
            ST_DIR:      state_next = ST_PROBE;
            ST_PROBE:
            begin
                if (key_eq || probe_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory read requests, busy and the result.
    always_comb
    begin
        rd_en       = 1'b0;
        rd_addr     = '0;
        busy        = 1'b1;
        done_next   = 1'b0;
        result_next = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (accept && ((cmd.op == OP_WRITE) || range_empty))
                begin
                    done_next = 1'b1;
                end
            end
            ST_RD_FIRST:
            begin
                rd_en   = 1'b1;
                rd_addr = lo_reg[IDX_W-1:0];
            end
            ST_RD_LAST:
            begin
                rd_en   = 1'b1;
                rd_addr = hi_reg[IDX_W-1:0];
            end
            ST_DIR:
            begin
                rd_en   = 1'b1;
                rd_addr = mid_init[IDX_W-1:0];
            end
            ST_PROBE:
            begin
                if (key_eq)
                begin
                    done_next            = 1'b1;
                    result_next.found    = 1'b1;
                    result_next.position = POS_W'(mid_reg[IDX_W-1:0]);
                end
                else if (probe_empty)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = mid_next[IDX_W-1:0];
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Element memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cmd.slot[IDX_W-1:0]] <= cmd.datum;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            done_reg        <= 1'b0;
            range_first_reg <= CFG_W'(0);
            range_last_reg  <= CFG_W'(1023);
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_RANGE_FIRST: range_first_reg <= cfg_data;
                    REG_RANGE_LAST:  range_last_reg  <= cfg_data;
                    default:         range_last_reg  <= range_last_reg;
                endcase
            end
        end
    end

    // Search datapath registers.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    lo_reg  <= PTR_W'(first_idx);
                    hi_reg  <= PTR_W'(last_idx);
                    key_reg <= cmd.datum;
                end
            end
            ST_RD_LAST:
            begin
                first_val_reg <= rdata_reg;
            end
            ST_DIR:
            begin
                desc_reg <= desc_now;
                mid_reg  <= mid_init;
            end
            ST_PROBE:
            begin
                lo_reg  <= lo_next;
                hi_reg  <= hi_next;
                mid_reg <= mid_next;
            end
            default:
            begin
                key_reg <= key_reg;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Whenever a result is shown, the block is ready for the next transaction.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // A write is acknowledged in the next cycle with a cleared result.
    a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.op == OP_WRITE)) |=>
            (done && !result.found && (result.position == '0)))
        else $error("write acknowledge missing or not cleared");

    // A hit always lies inside the configured range.
    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found) |->
            ((IDX_W'(result.position) >= first_idx) && (IDX_W'(result.position) <= last_idx)))
        else $error("hit position outside the search range");

    // A search that misses reports position zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.position == '0))
        else $error("miss reported with nonzero position");

endmodule

`default_nettype wire

// ----- bench/oabs_result_checker.sv -----
`timescale 1ns / 100ps

// Watches the command, result and register channels of the search block, keeps its own
// copy of the element store and bounds, and compares every result with the oldest
// outstanding prediction.
module oabs_result_checker
    import oabs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  cmd_t                  cmd,
    input  logic                  done,
    input  result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    failures,
    output int                    pending
);

    logic signed [DATA_W-1:0] words [DEPTH];
    logic [CFG_W-1:0]         span_first;
    logic [CFG_W-1:0]         span_last;
    result_t                  lookups_due [$];
    int                       mismatches = 0;

    // Binary search over the mirrored store, direction taken from the span's end points.
    function automatic result_t locate_key(input logic signed [DATA_W-1:0] key);
        result_t                  hit;
        int                       lo;
        int                       hi;
        int                       mid;
        bit                       descending;
        logic signed [DATA_W-1:0] probe;
        hit = '0;
        lo  = (int'(span_first) >= DEPTH) ? DEPTH - 1 : int'(span_first);
        hi  = (int'(span_last) >= DEPTH) ? DEPTH - 1 : int'(span_last);
        if (lo > hi)
        begin
            return hit;
        end
        descending = (words[lo] > words[hi]);
        while (lo <= hi)
        begin
            mid   = lo + (hi - lo) / 2;
            probe = words[mid];
            if (key == probe)
            begin
                hit.found    = 1'b1;
                hit.position = POS_W'(mid);
                return hit;
            end
            if ((key > probe) != descending)
            begin
                lo = mid + 1;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            span_first = '0;
            span_last  = CFG_W'(DEPTH - 1);
            lookups_due.delete();
        end
        else
        begin
            // Results are retired before new transactions are queued on the same edge.
            if (done)
            begin
                if (lookups_due.size() == 0)
                begin
                    $error("result with nothing outstanding: found %0d position %0d",
                           result.found, result.position);
                    mismatches++;
                end
                else
                begin
                    want = lookups_due.pop_front();
                    if (result.found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, result.found);
                        mismatches++;
                    end
                    if (result.position !== want.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               want.position, result.position);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_RANGE_FIRST: span_first = cfg_data;
                    REG_RANGE_LAST:  span_last  = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (cmd.op == OP_WRITE)
                begin
                    if (int'(cmd.slot) < DEPTH)
                    begin
                        words[cmd.slot] = cmd.datum;
                    end
                    lookups_due.push_back('0);
                end
                else
                begin
                    lookups_due.push_back(locate_key(cmd.datum));
                end
            end
        end
        failures <= mismatches;
        pending  <= lookups_due.size();
    end

endmodule

// ----- bench/tb_order_agnostic_binary_search.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the order-agnostic binary search block. The checker beside
// the block predicts and compares; this module only builds transactions and decides
// pass or fail from the checker's failure count and a cycle watchdog.
module tb_order_agnostic_binary_search;
    import oabs_pkg::*;

    localparam int ITEM_TARGET  = 1250;
    // Searches and sender pauses are both bounded, so a long silence
    // on every channel can only mean the block is stuck.
    localparam int QUIET_LIMIT  = 500;
    localparam int SETTLE_TICKS = 20;

    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    // How the contents of one searched span are laid out.
    typedef enum int {
        RISING,
        FALLING,
        FLAT,
        SCRAMBLED,
        CROSSED
    } layout_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  start    = 1'b0;
    cmd_t                  cmd      = '0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  busy;
    logic                  done;
    result_t               result;
    int                    failures;
    int                    pending;

    // Values the stimulus has written, used only to aim search keys at real elements.
    logic signed [DATA_W-1:0] held [DEPTH];
    int                       items_sent = 0;
    int                       burst_left = 1;
    bit                       gaps_on    = 1'b1;
    int                       quiet      = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    order_agnostic_binary_search dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    oabs_result_checker result_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .failures (failures),
        .pending  (pending)
    );

    // Drops start for the length that ticks gives and puts junk on the command bus, which the block
    // must ignore while start is low.
    task automatic pause(input int ticks);
        cmd_t junk;
        if (ticks > 0)
        begin
            junk.op    = 1'($urandom);
            junk.slot  = SLOT_W'($urandom);
            junk.datum = $urandom;
            start <= 1'b0;
            cmd   <= junk;
            repeat (ticks) @(posedge clk);
        end
    endtask

    // Presents one transaction and holds it until the block takes it. Start is left
    // high so that a burst runs back to back; gaps come only from pause.
    task automatic send(input op_t op, input logic [SLOT_W-1:0] slot,
                        input logic signed [DATA_W-1:0] datum);
        cmd_t c;
        c.op    = op;
        c.slot  = slot;
        c.datum = datum;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (op == OP_WRITE)
        begin
            held[slot] = datum;
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on)
            begin
                pause($urandom_range(0, 6));
            end
        end
    endtask

    // A write of random data to a random slot.
    task automatic scribble();
        send(OP_WRITE, SLOT_W'($urandom), $urandom);
    endtask

    // Holds the sender off until every outstanding transaction has produced its result.
    // The checker's count is registered, so drain waits for a clock edge before each look at it.
    task automatic drain();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    // Sets both bounds, only ever with the block idle.
    task automatic program_range(input logic [CFG_W-1:0] lo_idx, input logic [CFG_W-1:0] hi_idx);
        drain();
        cfg_we   <= 1'b1;
        cfg_addr <= REG_RANGE_FIRST;
        cfg_data <= lo_idx;
        @(posedge clk);
        cfg_addr <= REG_RANGE_LAST;
        cfg_data <= hi_idx;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One phase: choose a span and a layout, fill the span completely (unless its bounds are
    // crossed) so no search can touch an unwritten element, then search it with keys that mostly
    // hit, some that fall between neighbors, some at the word extremes and some entirely random.
    task automatic run_phase();
        logic signed [DATA_W-1:0] vals [DEPTH];
        int                       offsets [$];
        layout_t                  layout;
        int                       n;
        int                       lo;
        int                       pick;
        int                       m;
        int                       j;
        int                       r;
        int                       tmp;
        int unsigned              stride;
        longint                   acc;
        logic signed [DATA_W-1:0] key;

        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: layout = RISING;
            4, 5, 6:    layout = FALLING;
            7:          layout = FLAT;
            8:          layout = SCRAMBLED;
            default:    layout = CROSSED;
        endcase
        gaps_on = ($urandom_range(0, 9) < 7);

        // Mostly short spans keep searches quick; a few long ones exercise deep probing.
        pick = $urandom_range(0, 99);
        if (layout == CROSSED)
        begin
            n = $urandom_range(2, 24);
        end
        else if (pick < 80)
        begin
            n = $urandom_range(1, 24);
        end
        else if (pick < 96)
        begin
            n = $urandom_range(25, 120);
        end
        else
        begin
            n = $urandom_range(121, 400);
        end
        lo = $urandom_range(0, DEPTH - n);
        if ($urandom_range(0, 9) == 0)
        begin
            lo = $urandom_range(0, 1) ? 0 : DEPTH - n;
        end

        // Sorted values come from a running sum of random steps that saturates at the
        // top of the word range, which also produces runs of equal elements.
        case ($urandom_range(0, 3))
            0:       stride = 1;
            1:       stride = 8;
            2:       stride = 200000;
            default: stride = 32'h0800_0000;
        endcase
        if (layout == FLAT)
        begin
            stride = 0;
        end
        acc = ($urandom_range(0, 3) == 0) ? longint'(WORD_MIN) : longint'(int'($urandom));
        for (j = 0; j < n; j++)
        begin
            if (layout == SCRAMBLED)
            begin
                vals[j] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2 * n);
            end
            else
            begin
                vals[j] = acc[DATA_W-1:0];
                acc     = acc + $urandom_range(0, stride);
                if (acc > longint'(WORD_MAX))
                begin
                    acc = WORD_MAX;
                end
            end
            offsets.push_back(j);
        end
        if ($urandom_range(0, 1))
        begin
            for (j = n - 1; j > 0; j--)
            begin
                r          = $urandom_range(0, j);
                tmp        = offsets[j];
                offsets[j] = offsets[r];
                offsets[r] = tmp;
            end
        end

        if (layout == CROSSED)
        begin
            program_range(CFG_W'(lo + n - 1), CFG_W'(lo));
        end
        else
        begin
            program_range(CFG_W'(lo), CFG_W'(lo + n - 1));
            foreach (offsets[k])
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    scribble();
                end
                j = offsets[k];
                send(OP_WRITE, SLOT_W'((layout == FALLING) ? lo + n - 1 - j : lo + j),
                     vals[j]);
            end
        end

        m = $urandom_range(2, 8) + ((n < 60) ? n / 2 : 30);
        for (j = 0; j < m; j++)
        begin
            pick = $urandom_range(0, 99);
            r    = lo + $urandom_range(0, n - 1);
            if (pick < 55)
            begin
                key = held[r];
            end
            else if (pick < 70)
            begin
                key = held[r] + 1;
            end
            else if (pick < 80)
            begin
                key = held[r] - 1;
            end
            else if (pick < 90)
            begin
                key = $urandom;
            end
            else if (pick < 96)
            begin
                case ($urandom_range(0, 3))
                    0:       key = WORD_MIN;
                    1:       key = WORD_MAX;
                    2:       key = 0;
                    default: key = -1;
                endcase
            end
            else
            begin
                // A stray write between searches may break the span's order; the block
                // must still follow the same probe sequence.
                scribble();
                key = held[r];
            end
            send(OP_SEARCH, SLOT_W'($urandom), key);
        end
    endtask

    // Watchdog: any accepted transaction, result or register write resets the count.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
        begin
            quiet <= 0;
        end
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("order_agnostic_binary_search regression: fail");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            held[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(1, 12);

        // Ascending span at the bottom of the store holding both word extremes.
        program_range(0, 3);
        send(OP_WRITE, 0, WORD_MIN);
        send(OP_WRITE, 1, -1);
        send(OP_WRITE, 2, 0);
        send(OP_WRITE, 3, WORD_MAX);
        send(OP_SEARCH, 0, WORD_MIN);
        send(OP_SEARCH, 10'h3ff, WORD_MAX);
        send(OP_SEARCH, 0, 0);
        send(OP_SEARCH, 0, -1);
        send(OP_SEARCH, 0, 5);
        send(OP_SEARCH, 0, WORD_MIN + 1);

        // The top slot, a descending span and a span of equal elements.
        send(OP_WRITE, 10'h3ff, WORD_MAX);
        send(OP_WRITE, 4, WORD_MAX);
        send(OP_WRITE, 5, 100);
        send(OP_WRITE, 6, -100);
        send(OP_WRITE, 7, WORD_MIN);
        send(OP_WRITE, 8, 7);
        send(OP_WRITE, 9, 7);
        send(OP_WRITE, 10, 7);

        // A span of one element at the very top of the store.
        program_range(10'h3ff, 10'h3ff);
        send(OP_SEARCH, 0, WORD_MAX);
        send(OP_SEARCH, 0, 0);

        // Reversed bounds make the span empty, so nothing can be found.
        program_range(10'h3ff, 0);
        send(OP_SEARCH, 0, WORD_MAX);

        // First element greater than the last selects a descending search.
        program_range(4, 7);
        send(OP_SEARCH, 0, 100);
        send(OP_SEARCH, 0, WORD_MIN);

        // Equal end points fall back to an ascending search.
        program_range(8, 10);
        send(OP_SEARCH, 0, 7);
        send(OP_SEARCH, 0, 8);

        while (items_sent < ITEM_TARGET)
        begin
            run_phase();
        end

        drain();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (failures == 0 && pending == 0)
        begin
            $display("order_agnostic_binary_search regression: pass");
        end
        else
        begin
            $display("order_agnostic_binary_search regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/oabs_pkg.sv
src/order_agnostic_binary_search.sv
bench/oabs_result_checker.sv
bench/tb_order_agnostic_binary_search.sv
